// ===== rtl/core/hmlf_pkg.sv =====
package hmlf_pkg;

   // longest header in bytes, sets the width of the byte counter
   localparam int unsigned HEADER_MAX = 65535;
   localparam int unsigned COUNT_WIDTH = $clog2(HEADER_MAX + 1);

   localparam int unsigned FIELD_LEN = 18;
   localparam int unsigned STAGE_WIDTH = 5;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [1:0] STATUS_CONTENT     = 2'd0;
   localparam logic [1:0] STATUS_HEADER_ONLY = 2'd1;
   localparam logic [1:0] STATUS_NO_END      = 2'd2;
   localparam logic [1:0] STATUS_BAD_VALUE   = 2'd3;

   typedef struct packed {
      logic        emit;
      logic [31:0] total_length;
      logic [1:0]  status;
   } scan_result_type;

   // "\r\nContent-Length: "
   function automatic logic [7:0] field_char(input logic [STAGE_WIDTH-1:0] idx);
      logic [7:0] ch;
      begin
         case (idx)
            5'd0:    ch = CHAR_CR;
            5'd1:    ch = CHAR_LF;
            5'd2:    ch = "C";
            5'd3:    ch = "o";
            5'd4:    ch = "n";
            5'd5:    ch = "t";
            5'd6:    ch = "e";
            5'd7:    ch = "n";
            5'd8:    ch = "t";
            5'd9:    ch = "-";
            5'd10:   ch = "L";
            5'd11:   ch = "e";
            5'd12:   ch = "n";
            5'd13:   ch = "g";
            5'd14:   ch = "t";
            5'd15:   ch = "h";
            5'd16:   ch = ":";
            5'd17:   ch = " ";
            default: ch = 8'h00;
         endcase
         return ch;
      end
   endfunction

endpackage

// ===== rtl/core/http_message_length_finder_core.sv =====
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_data_byte[7:0], req_last_byte
// rsp_      out        rsp_valid/rsp_stall  rsp_total_length[31:0], rsp_status[1:0]
//
// One byte per cycle while no waiting result stalls the input; the per-byte
// match and count state loop closes through the scan registers.
// An accepted byte is held in the input register until the scan steps on it;
// a result it produces is then registered in the output register (rsp_valid).
// Reset (synchronous) empties both registers and clears all message state.
// A waiting result stalls only a byte that would produce another result.
module http_message_length_finder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_total_length,
   output logic [1:0]  rsp_status
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_total_ff;
   logic [1:0]  rsp_status_ff;

   logic        step;
   logic        req_take;
   hmlf_pkg::scan_result_type result;

   hmlf_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   assign step      = in_valid_ff && (!rsp_valid_ff || !rsp_stall || !result.emit);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step && result.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (step && result.emit) begin
         rsp_total_ff  <= result.total_length;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_length = rsp_total_ff;
   assign rsp_status       = rsp_status_ff;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == hmlf_pkg::STATUS_NO_END ||
                        rsp_status_ff == hmlf_pkg::STATUS_BAD_VALUE))
      |-> (rsp_total_ff == 32'd0))
      else $error("error status with nonzero length");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall && result.emit))
      else $error("input stalled without a blocked result");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (step && result.emit) |=> rsp_valid_ff)
      else $error("result not captured");

endmodule

// ===== rtl/core/hmlf_scan.sv =====
module hmlf_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   output hmlf_pkg::scan_result_type result
);

   localparam int unsigned CW = hmlf_pkg::COUNT_WIDTH;
   localparam int unsigned SW = hmlf_pkg::STAGE_WIDTH;

   // field stage once the pattern has matched
   localparam logic [SW-1:0] STAGE_NOSIGN  = SW'(hmlf_pkg::FIELD_LEN);
   localparam logic [SW-1:0] STAGE_SIGNED  = SW'(hmlf_pkg::FIELD_LEN + 1);
   localparam logic [SW-1:0] STAGE_VALID   = SW'(hmlf_pkg::FIELD_LEN + 2);
   localparam logic [SW-1:0] STAGE_INVALID = SW'(hmlf_pkg::FIELD_LEN + 3);

   localparam logic [1:0] PHASE_NONE   = 2'd0;
   localparam logic [1:0] PHASE_BEFORE = 2'd1;
   localparam logic [1:0] PHASE_DIGITS = 2'd2;
   localparam logic [1:0] PHASE_DONE   = 2'd3;

   logic [CW-1:0] header_count_ff, header_count_in;
   logic [1:0]    end_stage_ff, end_stage_in;
   logic [SW-1:0] field_stage_ff, field_stage_in;
   logic [1:0]    value_phase_ff, value_phase_in;
   logic [31:0]   content_value_ff, content_value_in;
   logic          message_done_ff, message_done_in;

   logic [CW-1:0] count;
   logic          is_digit;
   logic          is_blank;
   logic [SW-1:0] field_next;
   logic          end_hit;
   logic [35:0]   times_ten;
   logic [32:0]   sum;

   always_comb begin
      header_count_in  = header_count_ff;
      end_stage_in     = end_stage_ff;
      field_stage_in   = field_stage_ff;
      value_phase_in   = value_phase_ff;
      content_value_in = content_value_ff;
      message_done_in  = message_done_ff;
      result           = '0;

      count     = header_count_ff + CW'(1);
      is_digit  = (data_byte >= "0") && (data_byte <= "9");
      is_blank  = (data_byte == 8'h20) || (data_byte == 8'h09);
      times_ten = ({4'b0, content_value_ff} << 3) + ({4'b0, content_value_ff} << 1)
                  + 36'(data_byte[3:0]);
      field_next = '0;
      end_hit    = 1'b0;
      sum        = '0;

      if (!message_done_ff) begin
         header_count_in = count;

         if (value_phase_ff == PHASE_NONE) begin
            if (data_byte == hmlf_pkg::field_char(field_stage_ff)) begin
               field_next = field_stage_ff + SW'(1);
            end else begin
               field_next = (data_byte == hmlf_pkg::CHAR_CR) ? SW'(1) : SW'(0);
            end
            if (field_next == STAGE_NOSIGN) begin
               value_phase_in   = PHASE_BEFORE;
               content_value_in = '0;
            end
            field_stage_in = field_next;
         end else if (value_phase_ff == PHASE_BEFORE) begin
            if (is_digit) begin
               content_value_in = 32'(data_byte[3:0]);
               value_phase_in   = PHASE_DIGITS;
            end else if (field_stage_ff == STAGE_NOSIGN && is_blank) begin
               field_stage_in = field_stage_ff;
            end else if (field_stage_ff == STAGE_NOSIGN && data_byte == "+") begin
               field_stage_in = STAGE_SIGNED;
            end else begin
               field_stage_in = STAGE_INVALID;
               value_phase_in = PHASE_DONE;
            end
         end else if (value_phase_ff == PHASE_DIGITS) begin
            if (is_digit) begin
               content_value_in = (times_ten[35:32] != 4'd0) ? '1 : times_ten[31:0];
            end else begin
               field_stage_in = STAGE_VALID;
               value_phase_in = PHASE_DONE;
            end
         end

         // CR LF CR LF; the 2-bit stage wraps to zero on a full match
         if (data_byte == (end_stage_ff[0] ? hmlf_pkg::CHAR_LF : hmlf_pkg::CHAR_CR)) begin
            end_hit      = (end_stage_ff == 2'd3);
            end_stage_in = end_stage_ff + 2'd1;
         end else begin
            end_stage_in = (data_byte == hmlf_pkg::CHAR_CR) ? 2'd1 : 2'd0;
         end

         sum = {1'b0, content_value_in} + 33'(count);

         if (end_hit) begin
            result.emit     = 1'b1;
            message_done_in = 1'b1;
            if (value_phase_in == PHASE_NONE) begin
               result.total_length = 32'(count);
               result.status       = hmlf_pkg::STATUS_HEADER_ONLY;
            end else if (value_phase_in == PHASE_DIGITS ||
                         (value_phase_in == PHASE_DONE && field_stage_in == STAGE_VALID)) begin
               result.total_length = sum[32] ? '1 : sum[31:0];
               result.status       = hmlf_pkg::STATUS_CONTENT;
            end else begin
               result.status = hmlf_pkg::STATUS_BAD_VALUE;
            end
         end else if (data_byte == 8'h00 || last_byte ||
                      count >= CW'(hmlf_pkg::HEADER_MAX)) begin
            result.emit     = 1'b1;
            result.status   = hmlf_pkg::STATUS_NO_END;
            message_done_in = 1'b1;
         end
      end

      if (last_byte) begin
         header_count_in  = '0;
         end_stage_in     = '0;
         field_stage_in   = '0;
         value_phase_in   = PHASE_NONE;
         content_value_in = '0;
         message_done_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff  <= '0;
         end_stage_ff     <= '0;
         field_stage_ff   <= '0;
         value_phase_ff   <= PHASE_NONE;
         content_value_ff <= '0;
         message_done_ff  <= 1'b0;
      end else if (step) begin
         header_count_ff  <= header_count_in;
         end_stage_ff     <= end_stage_in;
         field_stage_ff   <= field_stage_in;
         value_phase_ff   <= value_phase_in;
         content_value_ff <= content_value_in;
         message_done_ff  <= message_done_in;
      end
   end

   a_phase_stage: assert property (@(posedge clock) disable iff (reset)
      (value_phase_ff == PHASE_NONE) |-> (field_stage_ff < STAGE_NOSIGN))
      else $error("field stage past pattern with no field seen");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !message_done_ff |-> (header_count_ff < CW'(hmlf_pkg::HEADER_MAX)))
      else $error("header count reached limit without a result");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (step && result.emit && !last_byte) |=> message_done_ff)
      else $error("result given but message not closed");

endmodule
